FILE: sv/upce_pkg.sv
// Shared types, constants and code tables for the UPC-E barcode encoder.
package upce_pkg;

    localparam int DIGIT_COUNT = 6;
    localparam int DIGIT_W     = 4;
    localparam int CODE_W      = 7;
    localparam int START_W     = 3;
    localparam int END_W       = 6;
    localparam int BAR_W       = START_W + DIGIT_COUNT * CODE_W + END_W;
    localparam int STATUS_W    = 2;
    localparam int SUM_W       = 8;

    localparam logic [START_W-1:0] START_GUARD = 3'b101;
    localparam logic [END_W-1:0]   END_GUARD   = 6'b010101;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_NS   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd2;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    typedef logic [DIGIT_W-1:0]                    t_digit;
    typedef logic [DIGIT_COUNT-1:0][DIGIT_W-1:0]   t_digit_vec;
    typedef logic [DIGIT_COUNT-1:0][CODE_W-1:0]    t_code_vec;

    // Result of the check stage, handed to the lanes and the merge stage.
    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        t_digit              check;
        logic                ns_one;
        t_digit_vec          digits;
    } t_stage;

    // L-parity pattern, first module in bit 6.
    function automatic logic [CODE_W-1:0] l_code(input t_digit d);
        logic [CODE_W-1:0] c;
        case (d)
            4'd0:    c = 7'h0D;
            4'd1:    c = 7'h19;
            4'd2:    c = 7'h13;
            4'd3:    c = 7'h3D;
            4'd4:    c = 7'h23;
            4'd5:    c = 7'h31;
            4'd6:    c = 7'h2F;
            4'd7:    c = 7'h3B;
            4'd8:    c = 7'h37;
            4'd9:    c = 7'h0B;
            default: c = '0;
        endcase
        return c;
    endfunction

    // G-parity pattern, first module in bit 6.
    function automatic logic [CODE_W-1:0] g_code(input t_digit d);
        logic [CODE_W-1:0] c;
        case (d)
            4'd0:    c = 7'h27;
            4'd1:    c = 7'h33;
            4'd2:    c = 7'h1B;
            4'd3:    c = 7'h21;
            4'd4:    c = 7'h1D;
            4'd5:    c = 7'h39;
            4'd6:    c = 7'h05;
            4'd7:    c = 7'h11;
            4'd8:    c = 7'h09;
            4'd9:    c = 7'h17;
            default: c = '0;
        endcase
        return c;
    endfunction

    // Parity word per number system and check digit; bit 5 is digit one, set = G.
    function automatic logic [DIGIT_COUNT-1:0] parity_of(input logic ns_one,
                                                         input t_digit check);
        logic [DIGIT_COUNT-1:0] p;
        case ({ns_one, check})
            5'h00:   p = 6'h38;
            5'h01:   p = 6'h34;
            5'h02:   p = 6'h32;
            5'h03:   p = 6'h31;
            5'h04:   p = 6'h2C;
            5'h05:   p = 6'h26;
            5'h06:   p = 6'h23;
            5'h07:   p = 6'h2A;
            5'h08:   p = 6'h29;
            5'h09:   p = 6'h25;
            5'h10:   p = 6'h07;
            5'h11:   p = 6'h0B;
            5'h12:   p = 6'h0D;
            5'h13:   p = 6'h0E;
            5'h14:   p = 6'h13;
            5'h15:   p = 6'h19;
            5'h16:   p = 6'h1C;
            5'h17:   p = 6'h15;
            5'h18:   p = 6'h16;
            5'h19:   p = 6'h1A;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

FILE: sv/upce_barcode_encoder_core.sv
// Top level of the UPC-E barcode encoder: check stage, six digit lanes, merge.
//
// Usage
//   Input channel: drive the number system, six data digits, the given
//   check digit and check_supplied, and raise start. A transaction is
//   taken at each rising edge with start high and busy low. busy is
//   always low: the block holds no state between codes and takes a new
//   transaction every cycle.
//   Result channel: o_done is high for exactly one cycle with
//   o_bar_modules (first module in bit 50, 1 = bar), o_check_value and
//   o_status (ok, bad number system, check mismatch). On any error the
//   bar pattern is all zeros.
//   Pipeline: two register stages lie between the accepting edge and the
//   edge that takes the result (check-digit sum and mod-10, then lane
//   encode and merge). Throughput: one code per cycle, as both
//   stages take a new transaction every cycle.
//   Reset: synchronous, active low; clears the valid flags of both stages
//   so no stale result is strobed. No results are lost to back-pressure:
//   the receiver cannot stall and must take each result as it appears.
module upce_barcode_encoder_core
    import upce_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [DIGIT_W-1:0]  i_number_system,
    input  logic [DIGIT_W-1:0]  i_digit_one,
    input  logic [DIGIT_W-1:0]  i_digit_two,
    input  logic [DIGIT_W-1:0]  i_digit_three,
    input  logic [DIGIT_W-1:0]  i_digit_four,
    input  logic [DIGIT_W-1:0]  i_digit_five,
    input  logic [DIGIT_W-1:0]  i_digit_six,
    input  logic [DIGIT_W-1:0]  i_given_check,
    input  logic                i_check_supplied,
    output logic                o_done,
    output logic [BAR_W-1:0]    o_bar_modules,
    output logic [DIGIT_W-1:0]  o_check_value,
    output logic [STATUS_W-1:0] o_status
);

    t_digit_vec             w_digits;
    t_stage                 w_stage;
    t_code_vec              w_codes;
    logic [DIGIT_COUNT-1:0] w_parity;
    logic                   w_accept;

    // Never stalls: every cycle can take a transaction.
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // Lane 0 carries digit one.
    assign w_digits = {i_digit_six, i_digit_five, i_digit_four,
                       i_digit_three, i_digit_two, i_digit_one};

    // Stage 1: expansion, weighted sum, check digit and status.
    upce_check u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_number_system  (i_number_system),
        .i_digits         (w_digits),
        .i_given_check    (i_given_check),
        .i_check_supplied (i_check_supplied),
        .o_stage          (w_stage)
    );

    // Parity word from number system and check; only meaningful when status ok,
    // which guarantees number system 0 or 1.
    assign w_parity = parity_of(w_stage.ns_one, w_stage.check);

    // Stage 2: six lanes encode their digits side by side.
    for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_lane
        upce_lane u_lane (
            .i_digit    (w_stage.digits[k]),
            .i_g_parity (w_parity[DIGIT_COUNT-1-k]),
            .o_code     (w_codes[k])
        );
    end

    // Guards plus lane outputs, zeroed on error, registered.
    upce_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stage       (w_stage),
        .i_codes       (w_codes),
        .o_done        (o_done),
        .o_bar_modules (o_bar_modules),
        .o_check_value (o_check_value),
        .o_status      (o_status)
    );

endmodule

FILE: sv/upce_check.sv
// Check-digit stage: UPC-A expansion, weighted sum, mod-10 and status.
module upce_check
    import upce_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_digit     i_number_system,
    input  t_digit_vec i_digits,
    input  t_digit     i_given_check,
    input  logic       i_check_supplied,
    output t_stage     o_stage
);

    logic                r_valid;
    logic [STATUS_W-1:0] r_status;
    t_digit              r_check;
    logic                r_ns_one;
    t_digit_vec          r_digits;

    logic [STATUS_W-1:0] n_status;
    t_digit              n_check;

    logic [SUM_W-1:0]    w_sum;
    logic [15:0]         w_prod;
    logic [4:0]          w_quot;
    logic [SUM_W-1:0]    w_rem_full;
    t_digit              w_rem;
    logic                w_decimal;

    function automatic logic [SUM_W-1:0] x1(input t_digit d);
        return {{(SUM_W-DIGIT_W){1'b0}}, d};
    endfunction

    function automatic logic [SUM_W-1:0] x3(input t_digit d);
        return {{(SUM_W-DIGIT_W){1'b0}}, d} + {{(SUM_W-DIGIT_W-1){1'b0}}, d, 1'b0};
    endfunction

    // Sum over the expanded form; the last data digit selects the layout.
    always_comb begin
        case (i_digits[5])
            4'd0, 4'd1, 4'd2: begin
                w_sum = x3(i_number_system) + x1(i_digits[0]) + x3(i_digits[1])
                      + x1(i_digits[5]) + x3(i_digits[2]) + x1(i_digits[3])
                      + x3(i_digits[4]);
            end
            4'd3: begin
                w_sum = x3(i_number_system) + x1(i_digits[0]) + x3(i_digits[1])
                      + x1(i_digits[2]) + x1(i_digits[3]) + x3(i_digits[4]);
            end
            4'd4: begin
                w_sum = x3(i_number_system) + x1(i_digits[0]) + x3(i_digits[1])
                      + x1(i_digits[2]) + x3(i_digits[3]) + x3(i_digits[4]);
            end
            default: begin
                w_sum = x3(i_number_system) + x1(i_digits[0]) + x3(i_digits[1])
                      + x1(i_digits[2]) + x3(i_digits[3]) + x1(i_digits[4])
                      + x3(i_digits[5]);
            end
        endcase
    end

    // sum / 10 by reciprocal: exact for sums up to 319
    assign w_prod     = {{(16-SUM_W){1'b0}}, w_sum} * 16'd205;
    assign w_quot     = w_prod[15:11];
    assign w_rem_full = w_sum - ({w_quot, 3'b000} + {2'b00, w_quot, 1'b0});
    assign w_rem      = w_rem_full[DIGIT_W-1:0];
    assign n_check    = (w_rem == 4'd0) ? 4'd0 : 4'd10 - w_rem;

    always_comb begin
        w_decimal = 1'b1;
        for (int k = 0; k < DIGIT_COUNT; k++) begin
            if (i_digits[k] > DIGIT_MAX) begin
                w_decimal = 1'b0;
            end
        end
    end

    always_comb begin
        if (!w_decimal) begin
            n_status = STATUS_BAD_NS;
        end else if (i_check_supplied && (i_given_check != n_check)) begin
            n_status = STATUS_MISMATCH;
        end else if (i_number_system > 4'd1) begin
            n_status = STATUS_BAD_NS;
        end else begin
            n_status = STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_check  <= n_check;
        r_ns_one <= i_number_system[0];
        r_digits <= i_digits;
    end

    assign o_stage = '{valid:  r_valid,
                       status: r_status,
                       check:  r_check,
                       ns_one: r_ns_one,
                       digits: r_digits};

endmodule

FILE: sv/upce_lane.sv
// One digit lane: picks the L or G pattern of its digit.
module upce_lane
    import upce_pkg::*;
(
    input  t_digit            i_digit,
    input  logic              i_g_parity,
    output logic [CODE_W-1:0] o_code
);

    assign o_code = i_g_parity ? g_code(i_digit) : l_code(i_digit);

endmodule

FILE: sv/upce_merge.sv
// Merge stage: joins guards and lane patterns into the registered result.
module upce_merge
    import upce_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_stage              i_stage,
    input  t_code_vec           i_codes,
    output logic                o_done,
    output logic [BAR_W-1:0]    o_bar_modules,
    output t_digit              o_check_value,
    output logic [STATUS_W-1:0] o_status
);

    logic                r_done;
    logic [BAR_W-1:0]    r_bars;
    t_digit              r_check;
    logic [STATUS_W-1:0] r_status;
    logic [BAR_W-1:0]    n_bars;

    always_comb begin
        n_bars = '0;
        if (i_stage.status == STATUS_OK) begin
            n_bars[BAR_W-1 -: START_W] = START_GUARD;
            for (int k = 0; k < DIGIT_COUNT; k++) begin
                n_bars[BAR_W-1-START_W-k*CODE_W -: CODE_W] = i_codes[k];
            end
            n_bars[END_W-1:0] = END_GUARD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bars   <= n_bars;
        r_check  <= i_stage.check;
        r_status <= i_stage.status;
    end

    assign o_done        = r_done;
    assign o_bar_modules = r_bars;
    assign o_check_value = r_check;
    assign o_status      = r_status;

endmodule

FILE: sv/upce_checker.sv
// Port-level checker for the UPC-E encoder, bound to the top level.
module upce_checker
    import upce_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_done,
    input logic [BAR_W-1:0]    o_bar_modules,
    input logic [DIGIT_W-1:0]  o_check_value,
    input logic [STATUS_W-1:0] o_status
);

    // every accepted transaction yields one result, through the check and merge registers
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("accepted transaction gave no result");

    // no result without a transaction
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##2 !o_done)
        else $error("result without a transaction");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != STATUS_OK) |-> (o_bar_modules == '0))
        else $error("bar pattern not cleared on error");

    a_guards: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == STATUS_OK) |->
            (o_bar_modules[BAR_W-1 -: START_W] == START_GUARD &&
             o_bar_modules[END_W-1:0] == END_GUARD))
        else $error("guard patterns wrong");

    a_check_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_check_value <= DIGIT_MAX &&
                    (o_status == STATUS_OK || o_status == STATUS_BAD_NS ||
                     o_status == STATUS_MISMATCH)))
        else $error("check value or status out of range");

endmodule

bind upce_barcode_encoder_core upce_checker u_upce_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_bar_modules (o_bar_modules),
    .o_check_value (o_check_value),
    .o_status      (o_status)
);
